// ===== rtl/lfsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the lowest free slot lease allocator.
// No dependencies; every other file of the block imports this package.
package lfsa_pkg;

    // Width of a timestamp on the request side.
    localparam int TIME_W  = 32;
    // Width of the reported slot number.
    localparam int GRANT_W = 6;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [GRANT_W-1:0] t_grant;

    // One entry of the slot table: busy flag and the time the lease ends.
    typedef struct packed {
        logic  busy;
        t_time release_time;
    } t_slot_entry;

endpackage

// ===== rtl/lfsa_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the lease allocator.
// Depends on lfsa_pkg for the payload types.

// Lease request channel: start and end time of one lease.
interface lfsa_req_if;
    import lfsa_pkg::*;

    logic  valid;
    logic  ready;
    t_time start_time;
    t_time end_time;

    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

// Grant channel: slot number and the all-busy flag.
interface lfsa_rsp_if;
    import lfsa_pkg::*;

    logic   valid;
    logic   ready;
    t_grant granted_slot;
    logic   all_busy;

    modport source (output valid, output granted_slot, output all_busy, input ready);
    modport sink   (input valid, input granted_slot, input all_busy, output ready);
endinterface

// ===== rtl/lfsa_slot_ram.sv =====
`timescale 1ns / 1ps
// Slot table memory: one write port and one registered read port.
// Depends on lfsa_pkg for the entry type.
module lfsa_slot_ram #(
    parameter int SLOTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]   i_wr_addr,
    input  lfsa_pkg::t_slot_entry      i_wr_data,
    input  logic [$clog2(SLOTS)-1:0]   i_rd_addr,
    output lfsa_pkg::t_slot_entry      o_rd_data
);
    import lfsa_pkg::*;

    t_slot_entry r_mem [SLOTS];
    t_slot_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lowest_free_slot_lease_allocator_top.sv =====
`timescale 1ns / 1ps
// Lease allocator top level: sequencer, shared release-time comparator and slot table.
// Depends on lfsa_pkg, lfsa_if and lfsa_slot_ram.

// One comparator walks the slot table one entry per cycle after a request
// is accepted, freeing every lease whose end time is at or before the
// request's start time and remembering the lowest free slot. A drain state
// then compares the last entry from the table's read register, and the grant
// is then written back through the table's single write port. The block is
// ready again in the same cycle as the grant appears, so requests are taken
// one at a time. The grant waits in an output register, so the next request
// can be accepted while the previous grant is still pending; a grant that is
// still pending when the next walk ends holds that walk in its grant state.
// After reset the block walks the table clearing the busy flags of every
// entry before it accepts its first request. The slot number reports the low
// six bits of the slot index; it is zero when all_busy is set.
module lowest_free_slot_lease_allocator_top #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lfsa_req_if.sink          i_req,
    lfsa_rsp_if.source        o_rsp
);
    import lfsa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W = (IDX_W > GRANT_W) ? IDX_W : GRANT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_GRANT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_q_idx;
    logic             r_q_vld;
    logic             r_found;
    logic [IDX_W-1:0] r_slot;
    t_time            r_start;
    t_time            r_end;
    logic             r_rsp_vld;
    t_grant           r_rsp_slot;
    logic             r_rsp_busy;

    t_slot_entry      rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot_entry      wr_data;
    logic             expired;
    logic             slot_free;
    logic [EXT_W-1:0] slot_ext;

    // Shared comparator: the entry read last cycle against the request start.
    assign expired   = rd_data.busy && (rd_data.release_time <= r_start);
    assign slot_free = !rd_data.busy || expired;
    assign slot_ext  = EXT_W'(r_slot);

    // Table write port: clearing pass, expiry write-back, or the grant itself.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_q_idx;
        wr_data = '{busy: 1'b0, release_time: r_end};
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
            end
            ST_GRANT: begin
                wr_en   = r_found && !(r_rsp_vld && !o_rsp.ready);
                wr_addr = r_slot;
                wr_data = '{busy: 1'b1, release_time: r_end};
            end
            default: begin
                wr_en = r_q_vld && expired;
            end
        endcase
    end

    lfsa_slot_ram #(
        .SLOTS (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // Sequencer and registered response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_q_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            // A pending grant leaves once the sink takes it, unless a new one replaces it.
            if (r_rsp_vld && o_rsp.ready && (r_state != ST_GRANT)) begin
                r_rsp_vld <= 1'b0;
            end

            // Remember the lowest free slot seen during the walk.
            if (r_q_vld && slot_free && !r_found) begin
                r_found <= 1'b1;
                r_slot  <= r_q_idx;
            end

            case (r_state)
                ST_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_start <= i_req.start_time;
                        r_end   <= i_req.end_time;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_q_vld <= 1'b1;
                    r_q_idx <= r_idx;
                    if (r_idx == LAST_IDX) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_q_vld <= 1'b0;
                    r_state <= ST_GRANT;
                end
                ST_GRANT: begin
                    if (!(r_rsp_vld && !o_rsp.ready)) begin
                        r_rsp_vld  <= 1'b1;
                        r_rsp_slot <= r_found ? slot_ext[GRANT_W-1:0] : '0;
                        r_rsp_busy <= !r_found;
                        r_idx      <= '0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_rsp_vld;
    assign o_rsp.granted_slot = r_rsp_slot;
    assign o_rsp.all_busy     = r_rsp_busy;

endmodule

// ===== tb/sv/lowest_free_slot_lease_allocator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of the lease allocator: directed and random lease requests,
// grants predicted in the bench and checked in order. Needs lfsa_pkg, lfsa_if and the top.
module lowest_free_slot_lease_allocator_top_test;
    import lfsa_pkg::*;

    localparam int SLOTS = 64;
    localparam int TOTAL_ITEMS = 1650;

    typedef struct packed {
        t_time starts_at;
        t_time ends_at;
    } lease_req_t;

    typedef struct packed {
        t_grant slot;
        logic   all_busy;
    } grant_t;

    logic i_clk;
    logic i_rst_n;

    lfsa_req_if req_if ();
    lfsa_rsp_if rsp_if ();

    lowest_free_slot_lease_allocator_top #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Requests still to be sent and grants still to be seen.
    lease_req_t pending_leases[$];
    grant_t     grants_due[$];

    // Shadow copy of the slot table.
    bit    lease_busy[SLOTS];
    t_time lease_until[SLOTS];

    int   total_req;
    int   req_count;
    int   fault_count;
    int   break_left[2];
    logic req_taken;

    always #4 i_clk = ~i_clk;

    // Free every lease that has run out, then hand out the lowest free slot.
    function automatic grant_t grant_lease(t_time starts_at, t_time ends_at);
        grant_t g;
        g.slot     = '0;
        g.all_busy = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (lease_busy[i] && lease_until[i] <= starts_at) begin
                lease_busy[i] = 1'b0;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!lease_busy[i]) begin
                lease_busy[i]  = 1'b1;
                lease_until[i] = ends_at;
                g.slot         = t_grant'(i);
                g.all_busy     = 1'b0;
                break;
            end
        end
        return g;
    endfunction

    // Test phase from progress: 0 free running, 1 sender idles, 2 receiver stalls, 3 both.
    function automatic int test_phase();
        return (req_count * 4) / total_req;
    endfunction

    // Per-cycle idle decision; now and then an idle stretch lasts a whole scan or more.
    function automatic bit take_break(int side, int pct);
        if (break_left[side] > 0) begin
            break_left[side]--;
            return 1'b1;
        end
        if ($urandom_range(99) >= pct) begin
            return 1'b0;
        end
        if ($urandom_range(15) == 0) begin
            break_left[side] = $urandom_range(SLOTS + 8, 1);
        end
        return 1'b1;
    endfunction

    function automatic void add_request(t_time starts_at, t_time ends_at);
        lease_req_t r;
        r.starts_at = starts_at;
        r.ends_at   = ends_at;
        pending_leases.push_back(r);
    endfunction

    // Hand-picked requests: reuse, same-moment release, extremes and a wrap of time.
    function automatic void add_directed();
        add_request(32'h0000_0000, 32'h0000_0000);
        // Slot 0 ran out at time 0 and is handed out again.
        add_request(32'h0000_0001, 32'h0000_0005);
        add_request(32'h0000_0002, 32'h0000_0003);
        // Slot 1 is released exactly at this start time.
        add_request(32'h0000_0003, 32'h0000_0064);
        add_request(32'h0000_0005, 32'hFFFF_FFFF);
        // Lease that ends before it starts.
        add_request(32'h0000_000A, 32'h0000_0004);
        add_request(32'h0000_000B, 32'h0000_0014);
        add_request(32'h5555_5555, 32'hAAAA_AAAA);
        add_request(32'h8000_0000, 32'hFFFF_FFFF);
        add_request(32'hAAAA_AAAA, 32'h5555_5555);
        add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'h0000_0000);
        // Time goes backwards; no check is made.
        add_request(32'h0000_0000, 32'h5555_5555);
        add_request(32'h0000_0000, 32'hFFFF_FFFF);
        add_request(32'h7FFF_FFFF, 32'h8000_0000);
        add_request(32'h8000_0000, 32'h7FFF_FFFF);
        add_request(32'h0000_FFFF, 32'hFFFF_0000);
        add_request(32'hFFFF_0000, 32'h0000_FFFF);
    endfunction

    // Mostly well-formed runs of ascending start times with random lease lengths,
    // some long enough to fill the table; short bursts of raw noise in between.
    function automatic void add_random(int want);
        t_time now_t;
        t_time step;
        t_time dur;
        t_time max_step;
        int    made;
        int    len;
        int    dur_mode;
        now_t = 32'h0000_1000;
        made  = 0;
        while (made < want) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++) begin
                    add_request($urandom(), $urandom());
                end
            end else begin
                len      = $urandom_range(120, 8);
                max_step = t_time'(1) << (4 * $urandom_range(5, 0));
                dur_mode = $urandom_range(3);
                if ($urandom_range(3) == 0) begin
                    now_t = $urandom();
                end
                for (int k = 0; k < len; k++) begin
                    // A fixed stride lets releases land exactly on later start times.
                    step  = (dur_mode == 2) ? max_step : $urandom_range(max_step, 1);
                    now_t = now_t + step;
                    case (dur_mode)
                        0: begin
                            dur = $urandom_range(2 * max_step, 0);
                        end
                        1: begin
                            dur = $urandom_range(120 * max_step, 40 * max_step);
                        end
                        2: begin
                            dur = max_step * $urandom_range(80, 0);
                        end
                        default: begin
                            if ($urandom_range(15) == 0) begin
                                dur = -t_time'($urandom_range(max_step, 0));
                            end else begin
                                dur = $urandom_range(64 * max_step, 1);
                            end
                        end
                    endcase
                    add_request(now_t, now_t + dur);
                end
            end
            made += len;
        end
    endfunction

    // Sample accepted requests and predict their grants.
    always @(posedge i_clk) begin : capture_req
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            grants_due.push_back(grant_lease(req_if.start_time, req_if.end_time));
            req_count <= req_count + 1;
        end
    end

    // Request driver: hold the current request until taken, then present the next one.
    always @(negedge i_clk) begin : drive_req
        logic next_valid;
        next_valid = req_if.valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (req_taken) begin
                void'(pending_leases.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid && pending_leases.size() != 0 &&
                !take_break(0, (test_phase() == 1) ? 75 : (test_phase() == 3) ? 11 : 0)) begin
                req_if.start_time <= pending_leases[0].starts_at;
                req_if.end_time   <= pending_leases[0].ends_at;
                next_valid = 1'b1;
            end
        end
        req_if.valid <= next_valid;
    end

    // Grant receiver back-pressure.
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= !take_break(1, (test_phase() == 2) ? 75 :
                                           (test_phase() == 3) ? 11 : 0);
        end
    end

    // Grant monitor: compare each grant with the oldest prediction.
    always @(posedge i_clk) begin : check_grant
        grant_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (grants_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected grant at %0t: slot %0d busy %0b", $time,
                             rsp_if.granted_slot, rsp_if.all_busy);
                end
            end else begin
                want = grants_due.pop_front();
                if (rsp_if.granted_slot !== want.slot || rsp_if.all_busy !== want.all_busy) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("grant mismatch at %0t: expected slot %0d busy %0b, got slot %0d busy %0b",
                                 $time, want.slot, want.all_busy,
                                 rsp_if.granted_slot, rsp_if.all_busy);
                    end
                end
            end
        end
    end

    // Build the stimulus, reset once, then wait for every grant to come back.
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.start_time = '0;
        req_if.end_time   = '0;
        rsp_if.ready      = 1'b0;
        req_taken         = 1'b0;
        req_count         = 0;
        fault_count       = 0;
        break_left[0]     = 0;
        break_left[1]     = 0;
        add_directed();
        add_random(TOTAL_ITEMS - pending_leases.size());
        total_req = pending_leases.size();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (req_count < total_req || grants_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lfsa_pkg.sv
rtl/lfsa_if.sv
rtl/lfsa_slot_ram.sv
rtl/lowest_free_slot_lease_allocator_top.sv
tb/sv/lowest_free_slot_lease_allocator_top_test.sv
